// ===== sv/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and constants of the move-to-front coder
// Holds the symbol width, the sequencer states and the control bundle that
// the sequencer broadcasts to every list cell.
// ----------------------------------------------------------------------------
package mtf_pkg;

   // width of a symbol and of a rank
   localparam int BYTE_W = 8;

   // sequencer states, one transaction at a time
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_UPDATE
   } state_type;

   // control broadcast from the sequencer to the cell chain
   typedef struct packed {
      logic              compare_en;
      logic              update_en;
      logic              decode;
      logic              restore;
      logic              found;
      logic [BYTE_W-1:0] in_byte;
      logic [BYTE_W-1:0] pos;
   } ctrl_type;

endpackage

// ===== sv/move_to_front_coder.sv =====
// ----------------------------------------------------------------------------
// move_to_front_coder: byte-wise move-to-front encoder and decoder
// A chain of list cells holds the symbol list. Each transaction is matched
// in every cell at once, the hit is reduced to a position and a symbol, and
// the list then shifts by one cell toward the back up to that position.
//
//   channel | direction | payload                        | marker
//   req_    | in        | tdata[7:0] in_byte             | tlast = block_end
//   rsp_    | out       | tdata[7:0] out_byte            | tlast = out_last
//   csr_    | in        | wdata[0] decode_mode           | write on csr_we
//
// Each transaction passes through accept, cell match, hit reduction and
// list update in turn. The result sits in an output register; the next
// transaction is accepted while it still waits. The list update waits
// while that register is full. Reset loads the identity list into the
// cells, and a block end restores it.
// ----------------------------------------------------------------------------
module move_to_front_coder #(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // block_end
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_last
   // configuration
   input  logic       csr_we,
   input  logic [0:0] csr_wdata    // [0] decode_mode
);

   localparam int BW = mtf_pkg::BYTE_W;
   localparam int N  = ALPHABET_SIZE;

   mtf_pkg::state_type state_ff, state_in;
   mtf_pkg::ctrl_type  ctrl;

   logic          mode_ff, mode_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [N:0][BW-1:0]   link;
   logic [N-1:0]         hit_vec;
   logic                 red_found;
   logic [BW-1:0]        red_pos;
   logic [BW-1:0]        red_sym;
   logic                 out_free;
   logic                 req_accept;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // configuration register
   always_comb begin
      mode_in = mode_ff;
      if (csr_we) begin
         mode_in = csr_wdata[0];
      end
   end

   // sequencer: next state, item capture, result register
   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      ctrl.compare_en = 1'b0;
      ctrl.update_en  = 1'b0;
      ctrl.decode     = mode_ff;
      ctrl.restore    = last_ff;
      ctrl.found      = red_found;
      ctrl.in_byte    = byte_ff;
      ctrl.pos        = red_pos;

      case (state_ff)
         mtf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               byte_in  = req_tdata;
               last_in  = req_tlast;
               state_in = mtf_pkg::ST_MATCH;
            end
         end
         mtf_pkg::ST_MATCH: begin
            ctrl.compare_en = 1'b1;
            state_in        = mtf_pkg::ST_REDUCE;
         end
         mtf_pkg::ST_REDUCE: begin
            state_in = mtf_pkg::ST_UPDATE;
         end
         mtf_pkg::ST_UPDATE: begin
            if (out_free) begin
               ctrl.update_en = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_last_in    = last_ff;
               if (!red_found) begin
                  rsp_data_in = byte_ff;
               end else if (mode_ff) begin
                  rsp_data_in = red_sym;
               end else begin
                  rsp_data_in = red_pos;
               end
               state_in = mtf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtf_pkg::ST_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // front of the chain takes the promoted symbol
   assign link[0] = mode_ff ? red_sym : byte_ff;

   // cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      mtf_cell #(
         .IDX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .prev_sym (link[i]),
         .sym      (link[i+1]),
         .hit      (hit_vec[i])
      );
   end

   // hit reduction
   mtf_reduce #(
      .NUM_CELLS(N)
   ) u_reduce (
      .clock (clock),
      .hit   (hit_vec),
      .syms  (link[N:1]),
      .found (red_found),
      .pos   (red_pos),
      .sym   (red_sym)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // the list stays a permutation, so at most one cell hits
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one list cell hit");

   // a transaction is not followed by another in the match, reduction and update states
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("request accepted while busy");

   // block end restores the identity list at both ends of the chain
   a_restore: assert property (@(posedge clock) disable iff (reset)
      (ctrl.update_en && last_ff) |=> (link[1] == '0) && (link[N] == BW'(N - 1)))
      else $error("list not restored after block end");

   // a result only appears after a list update
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == mtf_pkg::ST_UPDATE))
      else $error("response raised outside update");

endmodule

// ===== sv/mtf_cell.sv =====
// ----------------------------------------------------------------------------
// mtf_cell: one entry of the move-to-front symbol list
// Holds one symbol, flags a hit against the current transaction and, on
// update, reloads its own index at block end or takes its left neighbor's
// symbol when the promoted entry lies at or behind it.
// ----------------------------------------------------------------------------
module mtf_cell #(
   parameter int IDX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mtf_pkg::ctrl_type              ctrl,
   input  logic [mtf_pkg::BYTE_W-1:0]     prev_sym,
   output logic [mtf_pkg::BYTE_W-1:0]     sym,
   output logic                           hit
);

   localparam int BW = mtf_pkg::BYTE_W;
   localparam logic [BW-1:0] IDX_V = BW'(IDX);

   logic [BW-1:0] sym_ff, sym_in;
   logic          hit_ff, hit_in;

   // match on the stored symbol when encoding, on the position when decoding
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.compare_en) begin
         hit_in = ctrl.decode ? (IDX_V == ctrl.in_byte) : (sym_ff == ctrl.in_byte);
      end
   end

   // restore identity at block end, otherwise shift back behind the front
   always_comb begin
      sym_in = sym_ff;
      if (ctrl.update_en) begin
         if (ctrl.restore) begin
            sym_in = IDX_V;
         end else if (ctrl.found && (IDX_V <= ctrl.pos)) begin
            sym_in = prev_sym;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= IDX_V;
         hit_ff <= 1'b0;
      end else begin
         sym_ff <= sym_in;
         hit_ff <= hit_in;
      end
   end

   assign sym = sym_ff;
   assign hit = hit_ff;

endmodule

// ===== sv/mtf_reduce.sv =====
// ----------------------------------------------------------------------------
// mtf_reduce: hit reduction over the cell chain
// Folds the one-hot hit flags into a found flag, the hit position and the
// symbol stored there, all registered.
// ----------------------------------------------------------------------------
module mtf_reduce #(
   parameter int NUM_CELLS = 256
) (
   input  logic                                       clock,
   input  logic [NUM_CELLS-1:0]                       hit,
   input  logic [NUM_CELLS-1:0][mtf_pkg::BYTE_W-1:0]  syms,
   output logic                                       found,
   output logic [mtf_pkg::BYTE_W-1:0]                 pos,
   output logic [mtf_pkg::BYTE_W-1:0]                 sym
);

   localparam int BW = mtf_pkg::BYTE_W;

   logic          found_ff, found_in;
   logic [BW-1:0] pos_ff, pos_in;
   logic [BW-1:0] sym_ff, sym_in;

   // OR together the index and symbol of the single hit entry
   always_comb begin
      pos_in = '0;
      sym_in = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (hit[i]) begin
            pos_in = pos_in | BW'(i);
            sym_in = sym_in | syms[i];
         end
      end
      found_in = |hit;
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pos_ff   <= pos_in;
      sym_ff   <= sym_in;
   end

   assign found = found_ff;
   assign pos   = pos_ff;
   assign sym   = sym_ff;

endmodule
